>>> src/tlkd_pkg.sv
`default_nettype none

package tlkd_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 32;
  localparam int KEY_W        = 32;
  localparam int ACTION_W     = 3;
  localparam int STATUS_W     = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_DEL_KEY = 3'd1,
    ACT_DEL_NEW = 3'd2,
    ACT_DEL_OLD = 3'd3,
    ACT_READ    = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_UP,
    CM_DOWN,
    CM_LOAD
  } cell_mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

endpackage

`default_nettype wire

>>> src/tlkd_cell.sv
`default_nettype none

module tlkd_cell
  import tlkd_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cell_mode_t          mode,
  input  wire logic                up_live,
  input  wire logic [KEY_BITS-1:0] up_value,
  input  wire logic                dn_live,
  input  wire logic [KEY_BITS-1:0] dn_value,
  input  wire logic [KEY_BITS-1:0] load_value,
  output logic                     live,
  output logic [KEY_BITS-1:0]      value
);

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else begin
      unique case (mode)
        CM_UP:   live <= up_live;
        CM_DOWN: live <= dn_live;
        CM_LOAD: live <= 1'b1;
        default: live <= live;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (mode)
      CM_UP:   value <= up_value;
      CM_DOWN: value <= dn_value;
      CM_LOAD: value <= load_value;
      default: value <= value;
    endcase
  end

endmodule

`default_nettype wire

>>> src/tombstone_list_with_key_delete_core.sv
// Bounded key list with tombstones, held in a row of CAPACITY cells.
// Cell 0 holds the oldest entry, cell count-1 the newest.
// Command channel: an item (action, key) transfers when start is high and
// busy is low. Result channel: each result sits on value, status and last
// for one cycle, marked by strobe; the receiver cannot stall it.
// Insert: one result on the cycle after the transfer; the next item may
// follow at once. Any delete or read out on an empty list: the same.
// Delete key, delete newest, delete oldest and read out rotate the whole
// row once through the head cell, newest first. Read out gives one
// result per live key during the rotation, the final one marked by last.
// A delete gives its result at the end of the rotation, then shifts the
// row down one cell per cycle to drop tombstones at the oldest end. busy
// falls in the cycle that carries the final result, or after the last
// shift when the row must compact.
// Undefined actions transfer and are dropped with no result.
// Reset clears all live marks and the count; the list is empty.
`default_nettype none

module tombstone_list_with_key_delete_core
  import tlkd_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [ACTION_W-1:0] action,
  input  wire logic [KEY_W-1:0]    key,
  output logic                     strobe,
  output logic [KEY_W-1:0]         value,
  output logic [STATUS_W-1:0]      status,
  output logic                     last
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t              state, state_next;
  action_t             op;
  logic [KEY_BITS-1:0] key_r;
  logic [CW-1:0]       count;
  logic [CW-1:0]       newcount;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       lowlive;
  logic                anylive;
  logic                found;
  logic [IW-1:0]       shift_cnt;

  logic                cell_live  [CAPACITY];
  logic [KEY_BITS-1:0] cell_value [CAPACITY];

  cell_mode_t          chain_mode;
  logic                load_en;
  logic                accept;
  logic                is_empty;
  logic                is_full;

  logic                head_live;
  logic [KEY_BITS-1:0] head_value;
  logic                hit;
  logic                head_keep;
  logic                scan_end;
  logic                anylive_next;
  logic [IW-1:0]       lowlive_next;
  logic                found_next;
  logic [CW-1:0]       newcount_next;

  logic                strobe_next;
  logic [KEY_W-1:0]    value_next;
  status_t             status_next;
  logic                last_next;

  assign busy     = (state != S_IDLE);
  assign accept   = start && (state == S_IDLE);
  assign is_empty = (count == '0);
  assign is_full  = (count == CW'(CAPACITY));

  assign head_live  = cell_live[CAPACITY-1];
  assign head_value = cell_value[CAPACITY-1];

  always_comb begin
    hit = 1'b0;
    if (state == S_SCAN && head_live) begin
      unique case (op)
        ACT_DEL_KEY: hit = !found && (head_value == key_r);
        ACT_DEL_NEW: hit = !found;
        ACT_DEL_OLD: hit = (idx == '0);
        default:     hit = 1'b0;
      endcase
    end
  end

  assign head_keep     = head_live && !hit;
  assign scan_end      = (state == S_SCAN) && (idx == '0);
  assign anylive_next  = anylive || head_keep;
  assign lowlive_next  = head_keep ? idx : lowlive;
  assign found_next    = found || hit;
  assign newcount_next = (hit && op == ACT_DEL_NEW) ? CW'(idx) : newcount;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && !is_empty && (action == ACT_DEL_KEY || action == ACT_DEL_NEW ||
            action == ACT_DEL_OLD || action == ACT_READ)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = (anylive_next && lowlive_next != '0) ? S_SHIFT : S_IDLE;
        end
      end
      S_SHIFT: begin
        if (shift_cnt == IW'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    chain_mode  = CM_HOLD;
    load_en     = 1'b0;
    strobe_next = 1'b0;
    value_next  = '0;
    status_next = ST_OK;
    last_next   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_INSERT) begin
            strobe_next = 1'b1;
            last_next   = 1'b1;
            status_next = is_full ? ST_FULL : ST_OK;
            load_en     = !is_full;
          end else if (is_empty && (action == ACT_DEL_KEY || action == ACT_DEL_NEW ||
                       action == ACT_DEL_OLD || action == ACT_READ)) begin
            strobe_next = 1'b1;
            last_next   = 1'b1;
            status_next = ST_EMPTY;
          end
        end
      end
      S_SCAN: begin
        chain_mode = CM_UP;
        if (op == ACT_READ) begin
          strobe_next = head_live;
          value_next  = KEY_W'(head_value);
          last_next   = (idx == '0);
        end else if (scan_end) begin
          strobe_next = 1'b1;
          last_next   = 1'b1;
          status_next = (op == ACT_DEL_KEY && !found_next) ? ST_MISSING : ST_OK;
        end
      end
      S_SHIFT: chain_mode = CM_DOWN;
      default: chain_mode = CM_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      if (load_en) begin
        count <= count + CW'(1);
      end else if (scan_end && op != ACT_READ) begin
        count <= anylive_next ? newcount_next - CW'(lowlive_next) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    value  <= value_next;
    status <= status_next;
    last   <= last_next;
    if (accept) begin
      op       <= action_t'(action);
      key_r    <= key[KEY_BITS-1:0];
      idx      <= IW'(CAPACITY - 1);
      newcount <= count;
      lowlive  <= '0;
      anylive  <= 1'b0;
      found    <= 1'b0;
    end else if (state == S_SCAN) begin
      idx      <= idx - IW'(1);
      newcount <= newcount_next;
      lowlive  <= lowlive_next;
      anylive  <= anylive_next;
      found    <= found_next;
    end
    if (scan_end) begin
      shift_cnt <= lowlive_next;
    end else if (state == S_SHIFT) begin
      shift_cnt <= shift_cnt - IW'(1);
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    cell_mode_t          mode;
    logic                up_live;
    logic [KEY_BITS-1:0] up_value;
    logic                dn_live;
    logic [KEY_BITS-1:0] dn_value;

    assign mode = (load_en && count[IW-1:0] == IW'(k)) ? CM_LOAD : chain_mode;

    if (k == 0) begin : g_bottom
      assign up_live  = head_keep;
      assign up_value = head_value;
    end else begin : g_mid_up
      assign up_live  = cell_live[k-1];
      assign up_value = cell_value[k-1];
    end

    if (k == CAPACITY - 1) begin : g_top
      assign dn_live  = 1'b0;
      assign dn_value = '0;
    end else begin : g_mid_dn
      assign dn_live  = cell_live[k+1];
      assign dn_value = cell_value[k+1];
    end

    tlkd_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .mode       (mode),
      .up_live    (up_live),
      .up_value   (up_value),
      .dn_live    (dn_live),
      .dn_value   (dn_value),
      .load_value (key[KEY_BITS-1:0]),
      .live       (cell_live[k]),
      .value      (cell_value[k])
    );
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_oldest_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && count != '0) |-> cell_live[0])
    else $error("oldest entry is a tombstone while idle");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command transfer");

  a_no_result_in_shift: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |=> !strobe)
    else $error("result during compaction");
`endif

endmodule

`default_nettype wire

>>> tb/tombstone_list_with_key_delete_core_test.sv
`timescale 1ns / 100ps

module tombstone_list_with_key_delete_core_test;
  import tlkd_pkg::*;

  localparam int SLOTS = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 420;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_LEN = 50;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_C = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    k;
  } list_cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] val;
    status_t          st;
    logic             fin;
  } list_reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [ACTION_W-1:0] action = ACT_INSERT;
  logic [KEY_W-1:0]    key = '0;
  logic                busy;
  logic                strobe;
  logic [KEY_W-1:0]    value;
  logic [STATUS_W-1:0] status;
  logic                last;

  tombstone_list_with_key_delete_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .key(key),
    .strobe(strobe), .value(value), .status(status), .last(last)
  );

  // shadow list state
  logic [KEY_W-1:0] slot_key [SLOTS];
  bit               slot_alive [SLOTS];
  logic [5:0]       head_slot;
  logic [6:0]       used_slots;

  list_cmd_t   cmd_backlog [$];
  list_reply_t awaited_results [$];
  list_cmd_t   next_cmd;
  list_reply_t seen;
  logic [KEY_W-1:0] key_pool [8];

  int issued = 0;
  int granted = 0;
  int err_count = 0;
  int cycle_count = 0;
  int results_checked = 0;
  int readouts = 0;
  int full_drops = 0;
  int missing_keys = 0;
  int empty_hits = 0;
  int idle_by_phase [4] = '{0, 50, 0, 12};

  initial forever #5 clk = ~clk;

  function automatic int ring_slot(int offset);
    return (int'(head_slot) + offset) % SLOTS;
  endfunction

  task automatic reclaim_head();
    while (used_slots > 7'd0 && !slot_alive[head_slot]) begin
      head_slot = 6'((int'(head_slot) + 1) % SLOTS);
      used_slots = used_slots - 7'd1;
    end
  endtask

  task automatic apply_list_action(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] k);
    int i;
    int p;
    int n;
    bit alive_any;
    status_t st;
    st = ST_OK;
    alive_any = 0;
    for (i = 0; i < int'(used_slots); i++)
      if (slot_alive[ring_slot(i)]) alive_any = 1;
    case (act)
      ACT_INSERT: begin
        if (int'(used_slots) >= SLOTS) begin
          st = ST_FULL;
        end else begin
          p = ring_slot(int'(used_slots));
          slot_key[p] = k;
          slot_alive[p] = 1;
          used_slots = used_slots + 7'd1;
        end
      end
      ACT_DEL_KEY: begin
        if (!alive_any) begin
          st = ST_EMPTY;
        end else begin
          st = ST_MISSING;
          for (i = int'(used_slots); i > 0; i--) begin
            p = ring_slot(i - 1);
            if (st == ST_MISSING && slot_alive[p] && slot_key[p] == k) begin
              slot_alive[p] = 0;
              st = ST_OK;
            end
          end
          reclaim_head();
        end
      end
      ACT_DEL_NEW: begin
        st = ST_EMPTY;
        while (used_slots > 7'd0 && st == ST_EMPTY) begin
          p = ring_slot(int'(used_slots) - 1);
          used_slots = used_slots - 7'd1;
          if (slot_alive[p]) begin
            slot_alive[p] = 0;
            st = ST_OK;
          end
        end
        reclaim_head();
      end
      ACT_DEL_OLD: begin
        st = ST_EMPTY;
        for (i = 0; i < int'(used_slots); i++) begin
          p = ring_slot(i);
          if (st == ST_EMPTY && slot_alive[p]) begin
            slot_alive[p] = 0;
            st = ST_OK;
          end
        end
        reclaim_head();
      end
      ACT_READ: begin
        readouts++;
        n = 0;
        for (i = int'(used_slots); i > 0; i--) begin
          p = ring_slot(i - 1);
          if (slot_alive[p]) begin
            awaited_results.push_back('{val: slot_key[p], st: ST_OK, fin: 1'b0});
            n++;
          end
        end
        if (n == 0) begin
          empty_hits++;
          awaited_results.push_back('{val: '0, st: ST_EMPTY, fin: 1'b1});
        end else begin
          awaited_results[awaited_results.size() - 1].fin = 1'b1;
        end
      end
      default: ;
    endcase
    if (act inside {ACT_INSERT, ACT_DEL_KEY, ACT_DEL_NEW, ACT_DEL_OLD}) begin
      if (st == ST_FULL) full_drops++;
      if (st == ST_MISSING) missing_keys++;
      if (st == ST_EMPTY) empty_hits++;
      awaited_results.push_back('{val: '0, st: st, fin: 1'b1});
    end
  endtask

  // driver: present the next pending command once the current one has transferred
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (granted == issued) begin
      if (cmd_backlog.size() != 0 &&
          $urandom_range(99) >= idle_by_phase[(issued / PHASE_LEN) % 4]) begin
        next_cmd = cmd_backlog.pop_front();
        start <= 1'b1;
        action <= next_cmd.act;
        key <= next_cmd.k;
        issued <= issued + 1;
      end else begin
        start <= 1'b0;
        key <= $urandom;
      end
    end
  end

  // monitor: check results, then record the transfer of this edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else if (!rst) begin
      if (strobe) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing expected: value %h status %0d last %0b",
                 value, status, last);
          err_count++;
        end else begin
          seen = awaited_results.pop_front();
          results_checked++;
          if (value !== seen.val) begin
            $error("value: expected %h, got %h", seen.val, value);
            err_count++;
          end
          if (status !== seen.st) begin
            $error("status: expected %0d, got %0d", seen.st, status);
            err_count++;
          end
          if (last !== seen.fin) begin
            $error("last: expected %0b, got %0b", seen.fin, last);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        apply_list_action(action, key);
        granted <= granted + 1;
      end
    end
  end

  task automatic queue_cmd(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] k);
    cmd_backlog.push_back('{act: act, k: k});
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 75) return key_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  initial begin
    int added;
    int seg;
    int len;
    int r;
    int j;
    bit first;
    for (j = 0; j < SLOTS; j++) begin
      slot_alive[j] = 0;
      slot_key[j] = '0;
    end
    head_slot = '0;
    used_slots = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (j = 2; j < 8; j++) key_pool[j] = $urandom;

    queue_cmd(ACT_READ, $urandom);
    queue_cmd(ACT_DEL_KEY, 32'h0);
    queue_cmd(ACT_DEL_NEW, $urandom);
    queue_cmd(ACT_DEL_OLD, $urandom);
    queue_cmd(ACT_INSERT, 32'h0);
    queue_cmd(ACT_INSERT, 32'hFFFF_FFFF);
    queue_cmd(ACT_INSERT, 32'h5A5A_5A5A);
    queue_cmd(ACT_INSERT, 32'hA5A5_A5A5);
    queue_cmd(ACT_INSERT, 32'h0);
    queue_cmd(ACT_READ, $urandom);
    queue_cmd(ACT_DEL_KEY, 32'h1234_5678);
    queue_cmd(ACT_DEL_KEY, 32'h0);
    queue_cmd(ACT_READ, $urandom);
    queue_cmd(ACT_DEL_NEW, $urandom);
    queue_cmd(ACT_DEL_KEY, 32'hFFFF_FFFF);
    queue_cmd(ACT_DEL_OLD, $urandom);
    queue_cmd(ACT_READ, $urandom);
    queue_cmd(ACT_SPARE_A, 32'hFFFF_FFFF);
    queue_cmd(ACT_SPARE_B, 32'h0);
    queue_cmd(ACT_SPARE_C, 32'hFFFF_FFFF);
    queue_cmd(ACT_DEL_NEW, $urandom);
    queue_cmd(ACT_READ, $urandom);
    queue_cmd(ACT_DEL_NEW, $urandom);
    queue_cmd(ACT_DEL_KEY, 32'h5A5A_5A5A);

    added = 0;
    first = 1;
    while (added < RANDOM_ITEMS) begin
      seg = first ? 0 : $urandom_range(2);
      case (seg)
        0: begin
          len = first ? SLOTS + 3 : $urandom_range(60, 80);
          for (j = 0; j < len; j++) begin
            r = first ? 0 : $urandom_range(99);
            if (r < 80) queue_cmd(ACT_INSERT, pick_key());
            else if (r < 92) queue_cmd(ACT_DEL_KEY, pick_key());
            else queue_cmd(ACT_READ, $urandom);
          end
          queue_cmd(ACT_READ, $urandom);
          added += len + 1;
        end
        1: begin
          len = $urandom_range(20, 40);
          for (j = 0; j < len; j++) begin
            r = $urandom_range(99);
            if (r < 35) queue_cmd(ACT_INSERT, pick_key());
            else if (r < 60) queue_cmd(ACT_DEL_KEY, pick_key());
            else if (r < 70) queue_cmd(ACT_DEL_NEW, $urandom);
            else if (r < 80) queue_cmd(ACT_DEL_OLD, $urandom);
            else if (r < 95) queue_cmd(ACT_READ, $urandom);
            else begin
              queue_cmd(ACT_SPARE_A + 3'($urandom_range(2)), $urandom);
              added--;
            end
            added++;
          end
        end
        default: begin
          len = $urandom_range(20, 60);
          for (j = 0; j < len; j++) begin
            r = $urandom_range(99);
            if (r < 30) queue_cmd(ACT_DEL_NEW, $urandom);
            else if (r < 60) queue_cmd(ACT_DEL_OLD, $urandom);
            else if (r < 85) queue_cmd(ACT_DEL_KEY, pick_key());
            else if (r < 92) queue_cmd(ACT_INSERT, pick_key());
            else queue_cmd(ACT_READ, $urandom);
          end
          added += len;
        end
      endcase
      first = 0;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || granted != issued || awaited_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transfers and %0d checked results over %0d cycles.",
             granted, results_checked, cycle_count);
    $display("Read outs %0d, full drops %0d, missing keys %0d, empty-list reports %0d.",
             readouts, full_drops, missing_keys, empty_hits);
    if (err_count == 0 && awaited_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
